// File: rtl/sample_mean_rms_amplitude_assert.svh
// assertion macros for the sample statistics block
`ifndef SAMPLE_MEAN_RMS_AMPLITUDE_ASSERT_SVH
`define SAMPLE_MEAN_RMS_AMPLITUDE_ASSERT_SVH

`define SMRA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SMRA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/smra_pkg.sv
// shared types and constants for the sample statistics block
`timescale 1ns / 1ps
package smra_pkg;
    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int COUNT_BITS      = 11;
    localparam int AMP_BITS        = 17;
    localparam logic [16:0] SQRT2_Q16 = 17'd92682;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_last;
    } smra_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean_value;
        logic [SAMPLE_BITS-1:0]        rms_value;
        logic [AMP_BITS-1:0]           amplitude_value;
        logic [COUNT_BITS-1:0]         sample_count;
        logic                          overflow_flag;
    } smra_out_t;
endpackage

// File: rtl/sample_mean_rms_amplitude.sv
// top level: record memory, mean, rms and amplitude of one record
// load phase takes one beat per cycle; compute consists of two serial divisions,
// one memory pass at one entry per cycle and a 16 step square root
// next record loads while the previous result waits in the output register
// reset: synchronous active low, clears counters, sums and flags; memory not cleared
`timescale 1ns / 1ps
`include "sample_mean_rms_amplitude_assert.svh"
module sample_mean_rms_amplitude import smra_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  smra_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output smra_out_t m_data
);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int SUMW = SAMPLE_BITS + CW;
    localparam int DW   = SAMPLE_BITS + 1;
    localparam int SQW  = 2 * DW + CW;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_MDIV = 3'd1;
    localparam logic [2:0] ST_DEV  = 3'd2;
    localparam logic [2:0] ST_VDIV = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_AMP  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

    logic [2:0]                    state_reg;
    logic [CW-1:0]                 cnt_reg;
    logic signed [SUMW-1:0]        sum_reg;
    logic                          ovf_reg;
    logic                          go_reg;
    logic signed [SAMPLE_BITS-1:0] mean_reg;
    logic [CW-1:0]                 rd_idx_reg;
    logic [SAMPLE_BITS-1:0]        rd_data_reg;
    logic                          p1_reg, p2_reg, p3_reg;
    logic [DW-1:0]                 abs_reg;
    logic [2*DW-1:0]               sq_reg;
    logic [SQW-1:0]                acc_reg;
    logic [31:0]                   x_reg;
    logic [17:0]                   rem_reg;
    logic [15:0]                   root_reg;
    logic [4:0]                    k_reg;
    logic [AMP_BITS-1:0]           amp_reg;
    logic                          m_valid_reg;
    smra_out_t                     m_data_reg;

    logic                   s_acc;
    logic                   room;
    logic [SUMW-1:0]        mag;
    logic                   div_start, div_done;
    logic [SQW-1:0]         div_num, div_q;
    logic [SAMPLE_BITS-1:0] q_lo;
    logic signed [DW-1:0]   diff;
    logic [19:0]            r4;
    logic [17:0]            trial;
    logic [32:0]            prod;
    logic                   out_free;

    assign s_ready  = state_reg == ST_LOAD;
    assign s_acc    = s_valid && s_ready;
    assign room     = cnt_reg < CW'(MAX_SAMPLES);
    assign mag      = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    assign div_start = go_reg && (state_reg == ST_MDIV || state_reg == ST_VDIV);
    assign div_num  = (state_reg == ST_MDIV) ? SQW'(mag) : acc_reg;
    assign q_lo     = div_q[SAMPLE_BITS-1:0];
    assign diff     = $signed({rd_data_reg[SAMPLE_BITS-1], rd_data_reg})
                      - $signed({mean_reg[SAMPLE_BITS-1], mean_reg});
    assign r4       = {rem_reg, x_reg[31:30]};
    assign trial    = {root_reg, 2'b01};
    assign prod     = root_reg * SQRT2_Q16;
    assign out_free = !m_valid_reg || m_ready;

    smra_div #(.NUM_W(SQW), .DEN_W(CW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .numer(div_num), .denom(cnt_reg), .done(div_done), .quot(div_q)
    );

    always_ff @(posedge aclk) begin
        if (s_acc && room) begin
            mem[cnt_reg[AW-1:0]] <= s_data.sample;
        end
        rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        abs_reg <= diff[DW-1] ? DW'(-diff) : DW'(diff);
        sq_reg  <= abs_reg * abs_reg;
        amp_reg <= prod[32:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            go_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            p1_reg      <= 1'b0;
            p2_reg      <= 1'b0;
            p3_reg      <= 1'b0;
            rd_idx_reg  <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            p1_reg <= 1'b0;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            go_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_acc) begin
                        if (room) begin
                            cnt_reg <= cnt_reg + 1'b1;
                            sum_reg <= sum_reg + SUMW'(s_data.sample);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_data.sample_last) begin
                            state_reg <= ST_MDIV;
                            go_reg    <= 1'b1;
                        end
                    end
                end
                ST_MDIV: begin
                    if (div_done) begin
                        mean_reg   <= sum_reg[SUMW-1] ? -q_lo : q_lo;
                        rd_idx_reg <= '0;
                        acc_reg    <= '0;
                        state_reg  <= ST_DEV;
                    end
                end
                ST_DEV: begin
                    if (rd_idx_reg != cnt_reg) begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        p1_reg     <= 1'b1;
                    end
                    if (p3_reg) begin
                        acc_reg <= acc_reg + SQW'(sq_reg);
                    end
                    if (rd_idx_reg == cnt_reg && !p1_reg && !p2_reg && !p3_reg) begin
                        state_reg <= ST_VDIV;
                        go_reg    <= 1'b1;
                    end
                end
                ST_VDIV: begin
                    if (div_done) begin
                        x_reg     <= div_q[31:0];
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    x_reg <= {x_reg[29:0], 2'b00};
                    if (r4 >= {2'b00, trial}) begin
                        rem_reg  <= 18'(r4 - {2'b00, trial});
                        root_reg <= {root_reg[14:0], 1'b1};
                    end else begin
                        rem_reg  <= r4[17:0];
                        root_reg <= {root_reg[14:0], 1'b0};
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 5'd15) begin
                        state_reg <= ST_AMP;
                    end
                end
                ST_AMP: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.mean_value      <= mean_reg;
                        m_data_reg.rms_value       <= root_reg;
                        m_data_reg.amplitude_value <= amp_reg;
                        m_data_reg.sample_count    <= COUNT_BITS'(cnt_reg);
                        m_data_reg.overflow_flag   <= ovf_reg;
                        cnt_reg                    <= '0;
                        sum_reg                    <= '0;
                        ovf_reg                    <= 1'b0;
                        state_reg                  <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SMRA_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CW'(MAX_SAMPLES))
    `SMRA_ASSERT_IMP(a_rd_bound, aclk, aresetn, state_reg == ST_DEV, rd_idx_reg <= cnt_reg)
    `SMRA_ASSERT_NXT(a_fin_clear, aclk, aresetn, state_reg == ST_FIN && out_free,
                     m_valid_reg && cnt_reg == '0 && state_reg == ST_LOAD)
endmodule

// File: rtl/smra_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module smra_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    shifted;
    logic              fits;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                num_reg  <= numer;
                den_reg  <= denom;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
                num_reg  <= {num_reg[NUM_W-2:0], fits};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg;
endmodule
